### sv/hsv_to_rgb_converter_defines.svh
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion helpers for the converter RTL.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HSV_ASSERT_SAME(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("HSV converter check failed");
`define HSV_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("HSV converter check failed");
`else
`define HSV_ASSERT_SAME(lbl, clock, rstn, ante, cons)
`define HSV_ASSERT_NEXT(lbl, clock, rstn, ante, cons)
`endif

`endif

### sv/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, constants and stage payload types shared by the pipeline.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W       = 15;
	localparam int CHAN_W      = 8;
	localparam int SECTOR_SPAN = 3840;
	localparam int FULL_SCALE  = 255;
	localparam int PROD_SCALE  = FULL_SCALE * SECTOR_SPAN;
	localparam int FRAC_W      = $clog2(SECTOR_SPAN);
	localparam int SPAN_W      = $clog2(SECTOR_SPAN + 1);
	localparam int MAX_SECTOR  = ((2 ** HUE_W) - 1) / SECTOR_SPAN;
	localparam int SEC_CNT_W   = $clog2(MAX_SECTOR + 1);
	localparam int SF_W        = $clog2(PROD_SCALE + 1);
	localparam int PV_W        = 2 * CHAN_W;
	localparam int Y_W         = CHAN_W + SF_W;
	localparam int Y_SHIFT     = 8;
	localparam int Z_W         = Y_W - Y_SHIFT;
	localparam int DIV_REST    = PROD_SCALE / (2 ** Y_SHIFT);
	localparam int RECIP_N     = 32;
	localparam longint RECIP_M = ((64'd1 << RECIP_N) + DIV_REST - 1) / DIV_REST;
	localparam int RECIP_W     = 21;
	localparam int MP_W        = Z_W + RECIP_W;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	typedef struct packed {
		sector_t             sector;
		logic [FRAC_W-1:0]   frac;
		logic [CHAN_W-1:0]   sat;
		logic [CHAN_W-1:0]   val;
	} hsv2rgb_s1_t;

	typedef struct packed {
		sector_t             sector;
		logic [CHAN_W-1:0]   val;
		logic [SF_W-1:0]     sfq;
		logic [SF_W-1:0]     sft;
		logic [PV_W-1:0]     pv;
	} hsv2rgb_s2_t;

	typedef struct packed {
		sector_t             sector;
		logic [CHAN_W-1:0]   val;
		logic [Y_W-1:0]      yq;
		logic [Y_W-1:0]      yt;
		logic [CHAN_W-1:0]   p;
	} hsv2rgb_s3_t;

	typedef struct packed {
		sector_t             sector;
		logic [CHAN_W-1:0]   val;
		logic [CHAN_W-1:0]   p;
		logic [CHAN_W-1:0]   q;
		logic [CHAN_W-1:0]   t;
	} hsv2rgb_s4_t;

	function automatic logic [SEC_CNT_W-1:0] count_sectors(input logic [HUE_W-1:0] h);
		logic [SEC_CNT_W-1:0] n;
		n = '0;
		for (int k = 1; k <= MAX_SECTOR; k++) begin
			if (h >= HUE_W'(k * SECTOR_SPAN)) begin
				n = n + 1'b1;
			end
		end
		return n;
	endfunction

endpackage

### sv/hsv2rgb_sector.sv
// ---------------------------------------------------------------------------
// HSV to RGB sector split
// First stage: splits the hue into a sector and a position within it.
// ---------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]          hue,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]         saturation,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]         brightness,
	output logic                                   valid_s1,
	output hsv2rgb_pkg::hsv2rgb_s1_t               data_s1
);
	import hsv2rgb_pkg::*;

	logic [SEC_CNT_W-1:0] sec_full;
	logic [HUE_W-1:0]     frac_full;
	sector_t              sector;

	always_comb begin
		sec_full  = count_sectors(hue);
		frac_full = hue - HUE_W'(sec_full * SECTOR_SPAN);
		if (sec_full >= SEC_CNT_W'(SEC_MAGENTA_RED)) begin
			sector = SEC_MAGENTA_RED;
		end else begin
			sector = sector_t'(sec_full[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.sector <= sector;
		data_s1.frac   <= frac_full[FRAC_W-1:0];
		data_s1.sat    <= saturation;
		data_s1.val    <= brightness;
	end

endmodule

### sv/hsv2rgb_scale.sv
// ---------------------------------------------------------------------------
// HSV to RGB scaling products
// Second and third stages: saturation products, then value products and p.
// ---------------------------------------------------------------------------
module hsv2rgb_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  hsv2rgb_pkg::hsv2rgb_s1_t  data_s1,
	output logic                      valid_s3,
	output hsv2rgb_pkg::hsv2rgb_s3_t  data_s3
);
	import hsv2rgb_pkg::*;

	logic             valid_s2;
	hsv2rgb_s2_t      data_s2;
	logic [SPAN_W-1:0] rest;
	logic [PV_W:0]    pv_inc;
	logic [PV_W:0]    p_sum;

	always_comb begin
		rest   = SPAN_W'(SECTOR_SPAN) - SPAN_W'(data_s1.frac);
		pv_inc = {1'b0, data_s2.pv} + 1'b1;
		p_sum  = pv_inc + (pv_inc >> CHAN_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		data_s2.sector <= data_s1.sector;
		data_s2.val    <= data_s1.val;
		data_s2.sfq    <= SF_W'(data_s1.sat) * SF_W'(data_s1.frac);
		data_s2.sft    <= SF_W'(data_s1.sat) * SF_W'(rest);
		data_s2.pv     <= PV_W'(data_s1.val) * PV_W'(CHAN_W'(FULL_SCALE) - data_s1.sat);

		data_s3.sector <= data_s2.sector;
		data_s3.val    <= data_s2.val;
		data_s3.yq     <= Y_W'(data_s2.val) * Y_W'(SF_W'(PROD_SCALE) - data_s2.sfq);
		data_s3.yt     <= Y_W'(data_s2.val) * Y_W'(SF_W'(PROD_SCALE) - data_s2.sft);
		data_s3.p      <= p_sum[PV_W-1:CHAN_W];
	end

endmodule

### sv/hsv2rgb_divide.sv
// ---------------------------------------------------------------------------
// HSV to RGB constant division
// Fourth stage: divides the value products by the full product scale.
// ---------------------------------------------------------------------------
module hsv2rgb_divide (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s3,
	input  hsv2rgb_pkg::hsv2rgb_s3_t  data_s3,
	output logic                      valid_s4,
	output hsv2rgb_pkg::hsv2rgb_s4_t  data_s4
);
	import hsv2rgb_pkg::*;

	// Exact for every dividend below two to the power of the reduced width.
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_M);

	logic [MP_W-1:0] mq;
	logic [MP_W-1:0] mt;

	always_comb begin
		mq = MP_W'(data_s3.yq[Y_W-1:Y_SHIFT]) * MP_W'(RECIP);
		mt = MP_W'(data_s3.yt[Y_W-1:Y_SHIFT]) * MP_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		data_s4.sector <= data_s3.sector;
		data_s4.val    <= data_s3.val;
		data_s4.p      <= data_s3.p;
		data_s4.q      <= mq[RECIP_N+CHAN_W-1:RECIP_N];
		data_s4.t      <= mt[RECIP_N+CHAN_W-1:RECIP_N];
	end

endmodule

### sv/hsv_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline turning hue, saturation and value into 8-bit RGB.
// ---------------------------------------------------------------------------
// A pixel is transferred in when start is high and busy is low; busy is
// always low, so a new pixel may be offered on every clock cycle.
// Hue is in 1/64 degree units, saturation and brightness are 8-bit with
// 255 meaning full scale. Hues past the last sector are mapped to it.
// Each result appears on red, green and blue for exactly one cycle with
// strobe high after passing through all stages, one pixel per clock.
// The stages are sector split, saturation products,
// value products, reciprocal division and sector selection; the wide
// multipliers of the value products and the division set the clock period.
// Results leave in the order pixels entered. The receiver cannot stall,
// so no back-pressure exists and nothing is buffered beyond the stages.
// Asynchronous reset clears all stage valid bits, so no strobe follows
// reset until a new pixel has passed through.
// ---------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]      hue,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]     saturation,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]     brightness,
	output logic                               strobe,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]     red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]     green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]     blue
);
	import hsv2rgb_pkg::*;

	logic              in_valid;
	logic              valid_s1;
	logic              valid_s3;
	logic              valid_s4;
	hsv2rgb_s1_t       data_s1;
	hsv2rgb_s3_t       data_s3;
	hsv2rgb_s4_t       data_s4;
	logic [CHAN_W-1:0] r_sel;
	logic [CHAN_W-1:0] g_sel;
	logic [CHAN_W-1:0] b_sel;

	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	hsv2rgb_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	hsv2rgb_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	always_comb begin
		unique case (data_s4.sector)
			SEC_RED_YELLOW: begin
				r_sel = data_s4.val; g_sel = data_s4.t;   b_sel = data_s4.p;
			end
			SEC_YELLOW_GREEN: begin
				r_sel = data_s4.q;   g_sel = data_s4.val; b_sel = data_s4.p;
			end
			SEC_GREEN_CYAN: begin
				r_sel = data_s4.p;   g_sel = data_s4.val; b_sel = data_s4.t;
			end
			SEC_CYAN_BLUE: begin
				r_sel = data_s4.p;   g_sel = data_s4.q;   b_sel = data_s4.val;
			end
			SEC_BLUE_MAGENTA: begin
				r_sel = data_s4.t;   g_sel = data_s4.p;   b_sel = data_s4.val;
			end
			default: begin
				r_sel = data_s4.val; g_sel = data_s4.p;   b_sel = data_s4.q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		red   <= r_sel;
		green <= g_sel;
		blue  <= b_sel;
	end

	`HSV_ASSERT_SAME(a_latency, clk, arst_n, start && !busy, ##5 strobe)
	`HSV_ASSERT_SAME(a_value_present, clk, arst_n, strobe,
		red == $past(brightness, 5) || green == $past(brightness, 5) ||
		blue == $past(brightness, 5))
	`HSV_ASSERT_SAME(a_grey, clk, arst_n, strobe && $past(saturation, 5) == '0,
		red == $past(brightness, 5) && green == red && blue == red)

endmodule
